// ----- src/lcdws_pkg.sv -----
// Shared types, codes and constants of the character LCD write sequencer.
`default_nettype none

package lcdws_pkg;

   localparam int COUNTER_WIDTH = 16;

   typedef logic [COUNTER_WIDTH-1:0] cnt_type;

   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_CMD   = 2'd1;
   localparam logic [1:0] MODE_DATA  = 2'd2;
   localparam logic [1:0] MODE_START = 2'd3;

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_PULSE   = 3'd1;
   localparam logic [2:0] PH_SETTLE  = 3'd2;
   localparam logic [2:0] PH_EXTRA   = 3'd3;
   localparam logic [2:0] PH_POWERUP = 3'd4;

   localparam logic [2:0] REG_ENABLE_PULSE = 3'd0;
   localparam logic [2:0] REG_SHORT_WAIT   = 3'd1;
   localparam logic [2:0] REG_LONG_WAIT    = 3'd2;
   localparam logic [2:0] REG_POWER_UP     = 3'd3;
   localparam logic [2:0] REG_FIRST_WAKE   = 3'd4;
   localparam logic [2:0] REG_LATER_WAKE   = 3'd5;

   localparam logic [15:0] RST_ENABLE_PULSE = 16'd1;
   localparam logic [15:0] RST_SHORT_WAIT   = 16'd40;
   localparam logic [15:0] RST_LONG_WAIT    = 16'd2000;
   localparam logic [15:0] RST_POWER_UP     = 16'd20000;
   localparam logic [15:0] RST_FIRST_WAKE   = 16'd5000;
   localparam logic [15:0] RST_LATER_WAKE   = 16'd100;

   localparam logic [7:0] CMD_WAKE       = 8'h30;
   localparam logic [7:0] CMD_FUNC_SET   = 8'h38;
   localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
   localparam logic [7:0] CMD_CLEAR      = 8'h01;
   localparam logic [7:0] CMD_DISPLAY_ON = 8'h0F;
   localparam logic [7:0] LONG_WAIT_LIMIT = 8'h04;

   localparam logic [3:0] INIT_LEN        = 4'd7;
   localparam logic [3:0] LAST_WAKE_STEP  = 4'd2;

   typedef struct packed {
      logic [15:0] enable_pulse_ticks;
      logic [15:0] short_wait_ticks;
      logic [15:0] long_wait_ticks;
      logic [15:0] power_up_ticks;
      logic [15:0] first_wake_extra_ticks;
      logic [15:0] later_wake_extra_ticks;
   } cfg_type;

   typedef struct packed {
      logic       register_select;
      logic       enable_pin;
      logic [7:0] bus_byte;
      logic       ready_res;
      logic       init_active;
      logic       rejected;
   } res_type;

   function automatic cnt_type counter_load(input logic [15:0] v);
      return COUNTER_WIDTH'(v);
   endfunction

   function automatic logic [7:0] init_byte(input logic [2:0] idx);
      logic [7:0] b;
      unique case (idx)
         3'd0, 3'd1, 3'd2: b = CMD_WAKE;
         3'd3: b = CMD_FUNC_SET;
         3'd4: b = CMD_ENTRY_MODE;
         3'd5: b = CMD_CLEAR;
         3'd6: b = CMD_DISPLAY_ON;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

// ----- src/lcdws_csr.sv -----
// Configuration register file of the LCD write sequencer.
`default_nettype none

module lcdws_csr (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [2:0]           csr_index,
   input  wire logic [15:0]          csr_data,
   output lcdws_pkg::cfg_type        cfg
);

   lcdws_pkg::cfg_type cfg_ff;
   lcdws_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            lcdws_pkg::REG_ENABLE_PULSE: cfg_in.enable_pulse_ticks     = csr_data;
            lcdws_pkg::REG_SHORT_WAIT:   cfg_in.short_wait_ticks       = csr_data;
            lcdws_pkg::REG_LONG_WAIT:    cfg_in.long_wait_ticks        = csr_data;
            lcdws_pkg::REG_POWER_UP:     cfg_in.power_up_ticks         = csr_data;
            lcdws_pkg::REG_FIRST_WAKE:   cfg_in.first_wake_extra_ticks = csr_data;
            lcdws_pkg::REG_LATER_WAKE:   cfg_in.later_wake_extra_ticks = csr_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable_pulse_ticks     <= lcdws_pkg::RST_ENABLE_PULSE;
         cfg_ff.short_wait_ticks       <= lcdws_pkg::RST_SHORT_WAIT;
         cfg_ff.long_wait_ticks        <= lcdws_pkg::RST_LONG_WAIT;
         cfg_ff.power_up_ticks         <= lcdws_pkg::RST_POWER_UP;
         cfg_ff.first_wake_extra_ticks <= lcdws_pkg::RST_FIRST_WAKE;
         cfg_ff.later_wake_extra_ticks <= lcdws_pkg::RST_LATER_WAKE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/lcdws_core.sv -----
// Phase sequencer of the LCD write sequencer: one state update per request.
`default_nettype none

module lcdws_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire logic [1:0]           mode,
   input  wire logic [7:0]           byte_value,
   input  wire lcdws_pkg::cfg_type   cfg,
   output lcdws_pkg::res_type        res
);

   logic [2:0]          phase_ff, phase_in;
   lcdws_pkg::cnt_type  cnt_ff, cnt_in;
   logic [3:0]          init_step_ff, init_step_in;
   logic [7:0]          bus_ff, bus_in;
   logic                sel_ff, sel_in;
   logic                en_ff, en_in;
   logic                run_ff, run_in;

   logic                accepted;
   logic                rejected;

   always_comb begin
      logic       wr;
      logic [7:0] wr_byte;
      logic       wr_sel;
      logic       next_cmd;
      logic [3:0] step_inc;

      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      init_step_in = init_step_ff;
      bus_in       = bus_ff;
      sel_in       = sel_ff;
      en_in        = en_ff;
      run_in       = run_ff;
      accepted     = 1'b0;
      rejected     = 1'b0;
      wr           = 1'b0;
      wr_byte      = bus_ff;
      wr_sel       = 1'b0;
      next_cmd     = 1'b0;
      step_inc     = init_step_ff + 4'd1;

      if (phase_ff == lcdws_pkg::PH_IDLE) begin
         unique case (mode)
            lcdws_pkg::MODE_CMD: begin
               wr       = 1'b1;
               wr_byte  = byte_value;
               accepted = 1'b1;
            end
            lcdws_pkg::MODE_DATA: begin
               wr       = 1'b1;
               wr_byte  = byte_value;
               wr_sel   = 1'b1;
               accepted = 1'b1;
            end
            lcdws_pkg::MODE_START: begin
               run_in       = 1'b1;
               init_step_in = 4'd0;
               phase_in     = lcdws_pkg::PH_POWERUP;
               cnt_in       = lcdws_pkg::counter_load(cfg.power_up_ticks);
               accepted     = 1'b1;
            end
            lcdws_pkg::MODE_TICK: begin
               accepted = 1'b0;
            end
         endcase
      end else begin
         rejected = (mode != lcdws_pkg::MODE_TICK);
         if (cnt_ff > lcdws_pkg::cnt_type'(1)) begin
            cnt_in = cnt_ff - lcdws_pkg::cnt_type'(1);
         end else begin
            cnt_in = '0;
            unique case (phase_ff)
               lcdws_pkg::PH_PULSE: begin
                  en_in  = 1'b0;
                  sel_in = 1'b0;
                  phase_in = lcdws_pkg::PH_SETTLE;
                  if (!sel_ff && bus_ff < lcdws_pkg::LONG_WAIT_LIMIT) begin
                     cnt_in = lcdws_pkg::counter_load(cfg.long_wait_ticks);
                  end else begin
                     cnt_in = lcdws_pkg::counter_load(cfg.short_wait_ticks);
                  end
               end
               lcdws_pkg::PH_SETTLE: begin
                  priority if (!run_ff) begin
                     phase_in = lcdws_pkg::PH_IDLE;
                  end else if (init_step_ff == 4'd0) begin
                     phase_in = lcdws_pkg::PH_EXTRA;
                     cnt_in   = lcdws_pkg::counter_load(cfg.first_wake_extra_ticks);
                  end else if (init_step_ff <= lcdws_pkg::LAST_WAKE_STEP) begin
                     phase_in = lcdws_pkg::PH_EXTRA;
                     cnt_in   = lcdws_pkg::counter_load(cfg.later_wake_extra_ticks);
                  end else begin
                     next_cmd = 1'b1;
                  end
               end
               lcdws_pkg::PH_EXTRA: begin
                  next_cmd = 1'b1;
               end
               lcdws_pkg::PH_POWERUP: begin
                  init_step_in = 4'd0;
                  wr           = 1'b1;
                  wr_byte      = lcdws_pkg::init_byte(3'd0);
               end
               default: begin
                  phase_in = lcdws_pkg::PH_IDLE;
               end
            endcase
         end
      end

      if (next_cmd) begin
         if (step_inc >= lcdws_pkg::INIT_LEN) begin
            run_in       = 1'b0;
            init_step_in = 4'd0;
            phase_in     = lcdws_pkg::PH_IDLE;
            cnt_in       = '0;
         end else begin
            init_step_in = step_inc;
            wr           = 1'b1;
            wr_byte      = lcdws_pkg::init_byte(step_inc[2:0]);
         end
      end

      if (wr) begin
         bus_in   = wr_byte;
         sel_in   = wr_sel;
         en_in    = 1'b1;
         phase_in = lcdws_pkg::PH_PULSE;
         cnt_in   = lcdws_pkg::counter_load(cfg.enable_pulse_ticks);
      end
   end

   assign res.register_select = sel_in;
   assign res.enable_pin      = en_in;
   assign res.bus_byte        = bus_in;
   assign res.ready_res       = accepted;
   assign res.init_active     = run_in;
   assign res.rejected        = rejected;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= lcdws_pkg::PH_IDLE;
         cnt_ff       <= '0;
         init_step_ff <= 4'd0;
         bus_ff       <= 8'd0;
         sel_ff       <= 1'b0;
         en_ff        <= 1'b0;
         run_ff       <= 1'b0;
      end else if (step) begin
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         init_step_ff <= init_step_in;
         bus_ff       <= bus_in;
         sel_ff       <= sel_in;
         en_ff        <= en_in;
         run_ff       <= run_in;
      end
   end

   a_enable_only_in_pulse: assert property (@(posedge clock) disable iff (reset)
      en_ff |-> (phase_ff == lcdws_pkg::PH_PULSE))
      else $error("enable high outside pulse phase");

   a_powerup_in_init: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == lcdws_pkg::PH_POWERUP) |-> run_ff)
      else $error("power-up wait without start sequence");

   a_init_step_range: assert property (@(posedge clock) disable iff (reset)
      init_step_ff < lcdws_pkg::INIT_LEN)
      else $error("start sequence step out of range");

   a_accept_xor_reject: assert property (@(posedge clock) disable iff (reset)
      step |-> !(accepted && rejected))
      else $error("request both accepted and rejected");

   a_idle_holds_counter_zero: assert property (@(posedge clock) disable iff (reset)
      (step && phase_ff != lcdws_pkg::PH_IDLE && phase_in == lcdws_pkg::PH_IDLE)
      |=> (cnt_ff == '0))
      else $error("counter not cleared on return to idle");

endmodule

`default_nettype wire

// ----- src/char_lcd_write_sequencer.sv -----
// Top level of the character LCD write sequencer with request and response registers.
//
// Drives an 8-bit character LCD bus from a stream of requests: tick, command write, data
// write or start of the power-up sequence. Every request yields exactly one response that
// shows the pin levels after that request's tick, whether it was taken (ready_res) or
// refused because the sequencer was busy (rejected), and whether the start sequence runs.
// One request is taken per clock cycle unless a held response stalls the pipeline; a request
// passes the request register, the single phase update and the response register before its
// response becomes valid. Each request is one tick of the enable pulse and wait counters, so
// the timing registers are counted in requests, not in clock cycles. Write configuration
// only while no request is in flight.
`default_nettype none

module char_lcd_write_sequencer (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_mode,
   input  wire logic [7:0]  req_byte_value,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_register_select,
   output logic             rsp_enable_pin,
   output logic [7:0]       rsp_bus_byte,
   output logic             rsp_ready_res,
   output logic             rsp_init_active,
   output logic             rsp_rejected,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   lcdws_pkg::cfg_type cfg;
   lcdws_pkg::res_type step_res;

   logic               in_valid_ff, in_valid_in;
   logic [1:0]         in_mode_ff;
   logic [7:0]         in_byte_ff;
   logic               out_valid_ff, out_valid_in;
   lcdws_pkg::res_type out_res_ff;
   logic               advance;

   lcdws_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   lcdws_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .mode       (in_mode_ff),
      .byte_value (in_byte_ff),
      .cfg        (cfg),
      .res        (step_res)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      out_valid_in = out_valid_ff;
      priority if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_mode_ff <= lcdws_pkg::MODE_TICK;
         in_byte_ff <= 8'd0;
      end else if (req_valid && req_ready) begin
         in_mode_ff <= req_mode;
         in_byte_ff <= req_byte_value;
      end
      if (advance) begin
         out_res_ff <= step_res;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_register_select = out_res_ff.register_select;
   assign rsp_enable_pin      = out_res_ff.enable_pin;
   assign rsp_bus_byte        = out_res_ff.bus_byte;
   assign rsp_ready_res       = out_res_ff.ready_res;
   assign rsp_init_active     = out_res_ff.init_active;
   assign rsp_rejected        = out_res_ff.rejected;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |-> !advance)
      else $error("response register overwritten while held");

   a_request_reaches_response: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced request did not reach response register");

   a_stage_drains: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("request stage dropped a held request");

endmodule

`default_nettype wire

// ----- tb/sv/tb_char_lcd_write_sequencer.sv -----
// Self-checking testbench for the character LCD write sequencer.
module tb_char_lcd_write_sequencer;
   timeunit 1ns;
   timeprecision 1ps;

   import lcdws_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int LONG_HOLD = 400;
   localparam int LONG_HOLD_AT = 600;
   localparam int RANDOM_PHASES = 7;
   localparam int PHASE_ITEMS = 235;

   localparam logic [2:0] REG_SPARE0 = 3'd6;
   localparam logic [2:0] REG_SPARE1 = 3'd7;

   localparam logic [6:0][7:0] INIT_CMDS = {CMD_DISPLAY_ON, CMD_CLEAR, CMD_ENTRY_MODE,
                                            CMD_FUNC_SET, CMD_WAKE, CMD_WAKE, CMD_WAKE};

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] value;
   } lcd_request_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_mode = MODE_TICK;
   logic [7:0]  req_byte_value = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_register_select;
   logic        rsp_enable_pin;
   logic [7:0]  rsp_bus_byte;
   logic        rsp_ready_res;
   logic        rsp_init_active;
   logic        rsp_rejected;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = REG_ENABLE_PULSE;
   logic [15:0] csr_data = 16'h0000;

   lcd_request_t request_q[$];
   res_type      pin_state_q[$];

   // sequencer model state
   logic [2:0] seq_phase;
   cnt_type    seq_count;
   logic [3:0] seq_step;
   logic [7:0] seq_bus;
   logic       seq_rs;
   logic       seq_en;
   logic       seq_init;
   cfg_type    timing;

   int  errors = 0;
   int  n_items = 0;
   int  gap_max = 8;
   int  stall_max = 8;
   int  gap_left = 0;
   int  stall_left = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   bit  offering = 1'b0;
   int  results_seen = 0;
   int  quiet_cycles = 0;
   lcd_request_t head;
   res_type      want;

   char_lcd_write_sequencer i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_mode            (req_mode),
      .req_byte_value      (req_byte_value),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_register_select (rsp_register_select),
      .rsp_enable_pin      (rsp_enable_pin),
      .rsp_bus_byte        (rsp_bus_byte),
      .rsp_ready_res       (rsp_ready_res),
      .rsp_init_active     (rsp_init_active),
      .rsp_rejected        (rsp_rejected),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic void load_wait(input logic [2:0] ph, input logic [15:0] ticks);
      seq_phase = ph;
      seq_count = cnt_type'(ticks);
   endfunction

   function automatic void drive_write(input logic [7:0] b, input logic rs);
      seq_bus = b;
      seq_rs = rs;
      seq_en = 1'b1;
      load_wait(PH_PULSE, timing.enable_pulse_ticks);
   endfunction

   function automatic void next_init_cmd();
      seq_step = seq_step + 1'b1;
      if (seq_step >= INIT_LEN) begin
         seq_init = 1'b0;
         seq_step = '0;
         seq_phase = PH_IDLE;
         seq_count = '0;
      end else begin
         drive_write(INIT_CMDS[seq_step[2:0]], 1'b0);
      end
   endfunction

   // one tick of the sequencer: returns the pin levels after the update
   function automatic res_type lcd_tick(input logic [1:0] mode, input logic [7:0] b);
      res_type r;
      logic    took;
      logic    busy_hit;
      logic    was_data;
      took = 1'b0;
      busy_hit = 1'b0;
      if (seq_phase == PH_IDLE) begin
         if (mode == MODE_CMD || mode == MODE_DATA) begin
            drive_write(b, mode == MODE_DATA);
            took = 1'b1;
         end else if (mode == MODE_START) begin
            seq_init = 1'b1;
            seq_step = '0;
            load_wait(PH_POWERUP, timing.power_up_ticks);
            took = 1'b1;
         end
      end else begin
         busy_hit = (mode != MODE_TICK);
         if (seq_count > 1) begin
            seq_count = seq_count - 1'b1;
         end else begin
            seq_count = '0;
            case (seq_phase)
               PH_PULSE: begin
                  was_data = seq_rs;
                  seq_en = 1'b0;
                  seq_rs = 1'b0;
                  if (!was_data && seq_bus < LONG_WAIT_LIMIT)
                     load_wait(PH_SETTLE, timing.long_wait_ticks);
                  else
                     load_wait(PH_SETTLE, timing.short_wait_ticks);
               end
               PH_SETTLE: begin
                  if (!seq_init)
                     seq_phase = PH_IDLE;
                  else if (seq_step == 0)
                     load_wait(PH_EXTRA, timing.first_wake_extra_ticks);
                  else if (seq_step <= LAST_WAKE_STEP)
                     load_wait(PH_EXTRA, timing.later_wake_extra_ticks);
                  else
                     next_init_cmd();
               end
               PH_EXTRA: begin
                  next_init_cmd();
               end
               PH_POWERUP: begin
                  seq_step = '0;
                  drive_write(CMD_WAKE, 1'b0);
               end
               default: begin
                  seq_phase = PH_IDLE;
               end
            endcase
         end
      end
      r.register_select = seq_rs;
      r.enable_pin = seq_en;
      r.bus_byte = seq_bus;
      r.ready_res = took;
      r.init_active = seq_init;
      r.rejected = busy_hit;
      return r;
   endfunction

   function automatic int span(input logic [15:0] w);
      return (w == 0) ? 1 : int'(w);
   endfunction

   // ticks a request keeps the sequencer busy under the current timing
   function automatic int busy_len(input logic [1:0] mode, input logic [7:0] b);
      int p;
      int s;
      int l;
      p = span(timing.enable_pulse_ticks);
      s = span(timing.short_wait_ticks);
      l = span(timing.long_wait_ticks);
      case (mode)
         MODE_CMD:   return p + ((b < LONG_WAIT_LIMIT) ? l : s);
         MODE_DATA:  return p + s;
         MODE_START: return span(timing.power_up_ticks) + 7 * p + 6 * s + l
                            + span(timing.first_wake_extra_ticks)
                            + 2 * span(timing.later_wake_extra_ticks);
         default:    return 0;
      endcase
   endfunction

   function automatic void check_pin(input string pin, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, pin, exp_v, act_v);
         errors++;
      end
   endfunction

   task automatic push_req(input logic [1:0] mode, input logic [7:0] b);
      request_q.push_back('{mode: mode, value: b});
      n_items++;
   endtask

   task automatic pad(input int n);
      repeat (n) push_req(MODE_TICK, 8'($urandom_range(0, 255)));
   endtask

   // a request and ticks to finish it; noisy adds slack or rarely cuts it short, and busy requests
   task automatic send_burst(input logic [1:0] mode, input logic [7:0] b, input bit noisy);
      int busy;
      int n;
      busy = busy_len(mode, b);
      n = busy;
      if (noisy) begin
         n = busy + $urandom_range(0, 2);
         if ($urandom_range(0, 19) == 0)
            n = busy - $urandom_range(1, 2);
      end
      push_req(mode, b);
      for (int i = 0; i < n; i++) begin
         if (noisy && i < busy && $urandom_range(0, 9) == 0)
            push_req(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)));
         else
            push_req(MODE_TICK, 8'($urandom_range(0, 255)));
      end
   endtask

   task automatic drain();
      while (request_q.size() != 0 || offering || pin_state_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [15:0] data);
      csr_index <= idx;
      csr_data <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_ENABLE_PULSE: timing.enable_pulse_ticks = data;
         REG_SHORT_WAIT:   timing.short_wait_ticks = data;
         REG_LONG_WAIT:    timing.long_wait_ticks = data;
         REG_POWER_UP:     timing.power_up_ticks = data;
         REG_FIRST_WAKE:   timing.first_wake_extra_ticks = data;
         REG_LATER_WAKE:   timing.later_wake_extra_ticks = data;
         default: ;
      endcase
   endtask

   // hold the sender until every response is back, then load new timing
   task automatic retime(input cfg_type t, input bit spare);
      drain();
      csr_write(REG_ENABLE_PULSE, t.enable_pulse_ticks);
      csr_write(REG_SHORT_WAIT, t.short_wait_ticks);
      csr_write(REG_LONG_WAIT, t.long_wait_ticks);
      csr_write(REG_POWER_UP, t.power_up_ticks);
      csr_write(REG_FIRST_WAKE, t.first_wake_extra_ticks);
      csr_write(REG_LATER_WAKE, t.later_wake_extra_ticks);
      if (spare) begin
         csr_write(REG_SPARE0, 16'($urandom_range(0, 65535)));
         csr_write(REG_SPARE1, 16'($urandom_range(0, 65535)));
      end
      csr_valid <= 1'b0;
   endtask

   function automatic logic [15:0] pick_ticks();
      case ($urandom_range(0, 9))
         0:       return 16'd0;
         1:       return 16'd1;
         9:       return 16'($urandom_range(7, 24));
         default: return 16'($urandom_range(2, 6));
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         offering = 1'b0;
         gap_left = 0;
         seq_phase = PH_IDLE;
         seq_count = '0;
         seq_step = '0;
         seq_bus = '0;
         seq_rs = 1'b0;
         seq_en = 1'b0;
         seq_init = 1'b0;
         timing = '{RST_ENABLE_PULSE, RST_SHORT_WAIT, RST_LONG_WAIT,
                    RST_POWER_UP, RST_FIRST_WAKE, RST_LATER_WAKE};
      end else begin
         if (req_valid && req_ready) begin
            pin_state_q.push_back(lcd_tick(req_mode, req_byte_value));
            offering = 1'b0;
         end
         if (!offering) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (request_q.size() != 0) begin
               head = request_q.pop_front();
               req_mode <= head.mode;
               req_byte_value <= head.value;
               offering = 1'b1;
               gap_left = $urandom_range(0, gap_max);
            end
         end
         req_valid <= offering;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pin_state_q.size() == 0) begin
               $display("%0t: response with none expected: rs %0h en %0h bus %0h", $time,
                        rsp_register_select, rsp_enable_pin, rsp_bus_byte);
               errors++;
            end else begin
               want = pin_state_q.pop_front();
               check_pin("register_select", want.register_select, rsp_register_select);
               check_pin("enable_pin", want.enable_pin, rsp_enable_pin);
               check_pin("bus_byte", want.bus_byte, rsp_bus_byte);
               check_pin("ready_res", want.ready_res, rsp_ready_res);
               check_pin("init_active", want.init_active, rsp_init_active);
               check_pin("rejected", want.rejected, rsp_rejected);
            end
            results_seen++;
            stall_left = $urandom_range(0, stall_max);
         end
         if (!hold_done && results_seen >= LONG_HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready)
                   || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
            $display("tb_char_lcd_write_sequencer NOT OK");
            $finish;
         end
      end
   end

   initial begin
      cfg_type     t;
      int          goal;
      int          r;
      logic [7:0]  b;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // power-on timing: one data write, busy requests of every kind
      push_req(MODE_TICK, 8'hFF);
      push_req(MODE_DATA, 8'hA5);
      push_req(MODE_CMD, 8'h00);
      push_req(MODE_DATA, 8'hFF);
      push_req(MODE_START, 8'h00);
      pad(busy_len(MODE_DATA, 8'hA5) - 3);
      push_req(MODE_TICK, 8'h00);

      // zero timings act as one tick
      t = '{16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd1};
      retime(t, 1'b1);
      send_burst(MODE_CMD, 8'h00, 1'b0);
      send_burst(MODE_CMD, 8'h03, 1'b0);
      send_burst(MODE_CMD, 8'h04, 1'b0);
      send_burst(MODE_CMD, 8'hFF, 1'b0);
      send_burst(MODE_DATA, 8'h00, 1'b0);
      send_burst(MODE_DATA, 8'hFF, 1'b0);
      push_req(MODE_START, 8'h00);
      push_req(MODE_START, 8'hFF);
      push_req(MODE_CMD, 8'h55);
      pad(busy_len(MODE_START, 8'h00) - 2);
      push_req(MODE_TICK, 8'hAA);

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         t.enable_pulse_ticks = pick_ticks();
         t.short_wait_ticks = pick_ticks();
         t.long_wait_ticks = pick_ticks();
         t.power_up_ticks = pick_ticks();
         t.first_wake_extra_ticks = pick_ticks();
         t.later_wake_extra_ticks = pick_ticks();
         retime(t, $urandom_range(0, 3) == 0);
         gap_max = (ph % 3 == 2) ? 0 : 8;
         stall_max = (ph % 3 == 1) ? 0 : 8;
         goal = n_items + PHASE_ITEMS;
         while (n_items < goal) begin
            r = $urandom_range(0, 19);
            b = 8'($urandom_range(0, 255));
            if (r < 8) begin
               if ($urandom_range(0, 1))
                  b = 8'($urandom_range(0, 3));
               send_burst(MODE_CMD, b, 1'b1);
            end else if (r < 16) begin
               send_burst(MODE_DATA, b, 1'b1);
            end else if (r < 18) begin
               send_burst(MODE_START, b, 1'b1);
            end else begin
               send_burst(MODE_TICK, b, 1'b1);
            end
         end
      end

      // widest timing with no idling: start a write and probe it while still busy
      t = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
      retime(t, 1'b0);
      gap_max = 0;
      stall_max = 0;
      push_req(MODE_CMD, 8'h02);
      pad(20);
      push_req(MODE_DATA, 8'h5A);
      push_req(MODE_START, 8'h00);
      push_req(MODE_TICK, 8'h00);

      drain();
      repeat (16) @(posedge clock);
      if (errors == 0 && pin_state_q.size() == 0)
         $display("tb_char_lcd_write_sequencer OK");
      else
         $display("tb_char_lcd_write_sequencer NOT OK");
      $finish;
   end

endmodule
